/* design/ircu_pkg.sv */
// Shared types, codes and constants of the index range coalescer.
`default_nettype none
package ircu_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int START_W = 31;
    localparam int COUNT_W = 32;
    localparam int OFFS_W = 34;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [COUNT_W:0]   sum;
        logic [COUNT_W-1:0] sat;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXTEND,
        ST_MCHECK,
        ST_MERGE,
        ST_SHDN,
        ST_SHUP,
        ST_INSW,
        ST_DRAIN
    } state_t;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    localparam logic [2:0] STAT_EMPTY     = 3'd0;
    localparam logic [2:0] STAT_CONTAINED = 3'd1;
    localparam logic [2:0] STAT_EXTENDED  = 3'd2;
    localparam logic [2:0] STAT_MERGED    = 3'd3;
    localparam logic [2:0] STAT_INSERTED  = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_DRAINED   = 3'd6;

endpackage
`default_nettype wire

/* design/index_range_coalescer_unit.sv */
// Top level: sequencer of the sorted range table, with table RAM and shared adder.
//
// Keeps up to TABLE_DEPTH index ranges sorted by start. Pulse start while busy is low to
// issue a transaction: op=0 offers a range and returns exactly one status, op=1 drains
// every stored range in order (one result per entry, last marks the final one) and empties
// the table. Each result is valid for exactly one cycle on done; there is no back-pressure,
// so the receiver must take it in that cycle. An append scans one entry per cycle (the
// table sits in a RAM with one read per cycle) and then checks the end of the table; an
// extend adds the count and checks the next entry for a merge, a merge writes the joined
// entry and moves each later entry down, and an insert in front of stored entries moves
// them up from the top down and then writes the new one. The worst case is an insert at
// the head of a table one short of full. The status shows in the same cycle that busy
// falls. A zero-count append answers the next cycle without going busy. A drain gives its
// results in consecutive cycles, each entry read from the RAM, then registered at outputs.
// offset_in_bytes is set through cfg_write/cfg_data and may only change while idle.
`default_nettype none
module index_range_coalescer_unit #(
    parameter int TABLE_DEPTH = ircu_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_data,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic                          op,
    input  wire logic [ircu_pkg::START_W-1:0]  first_index,
    input  wire logic [ircu_pkg::START_W-1:0]  item_count,
    output      logic                          done,
    output      logic                          kind,
    output      logic [2:0]                    status,
    output      logic [ircu_pkg::OFFS_W-1:0]   range_start,
    output      logic [ircu_pkg::COUNT_W-1:0]  range_count,
    output      logic                          table_empty,
    output      logic                          last
);
    import ircu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    state_t               state_reg, state_next;
    logic [CW-1:0]        used_reg, used_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 pos_found_reg, pos_found_next;
    logic [START_W-1:0]   idx_reg, idx_next;
    logic [START_W-1:0]   cnt_reg, cnt_next;
    logic [START_W-1:0]   s_reg, s_next;
    logic [COUNT_W-1:0]   c_reg, c_next;
    logic                 offset_reg, offset_next;

    logic                 done_reg, done_next;
    logic                 kind_reg, kind_next;
    logic [2:0]           status_reg, status_next;
    logic [OFFS_W-1:0]    range_start_reg, range_start_next;
    logic [COUNT_W-1:0]   range_count_reg, range_count_next;
    logic                 table_empty_reg, table_empty_next;
    logic                 last_reg, last_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    entry_t               wr_entry;
    logic [AW-1:0]        rd_addr;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t               rd_entry;
    entry_t               new_entry;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    logic [CW-1:0]        i_inc, i_inc2, j_inc, j_dec, used_dec;
    logic [COUNT_W:0]     idx_ext;
    logic                 fin_append;
    logic [2:0]           fin_status;

    ircu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ircu_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rd_entry  = entry_t'(rd_data);
    assign new_entry = '{start: idx_reg, count: {1'b0, cnt_reg}};
    assign i_inc     = i_reg + ONE_C;
    assign i_inc2    = i_reg + TWO_C;
    assign j_inc     = j_reg + ONE_C;
    assign j_dec     = j_reg - ONE_C;
    assign used_dec  = used_reg - ONE_C;
    assign idx_ext   = {2'b00, idx_reg};

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        pos_next         = pos_reg;
        pos_found_next   = pos_found_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        s_next           = s_reg;
        c_next           = c_reg;
        offset_next      = cfg_write ? cfg_data : offset_reg;
        done_next        = 1'b0;
        kind_next        = kind_reg;
        status_next      = status_reg;
        range_start_next = range_start_reg;
        range_count_next = range_count_reg;
        table_empty_next = table_empty_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_entry         = new_entry;
        rd_addr          = '0;
        alu_req          = '0;
        fin_append       = 1'b0;
        fin_status       = STAT_EMPTY;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = first_index;
                    cnt_next = item_count;
                    if (op == OP_DRAIN)
                    begin
                        if (used_reg == '0)
                        begin
                            done_next        = 1'b1;
                            kind_next        = KIND_DRAIN;
                            status_next      = STAT_DRAINED;
                            range_start_next = '0;
                            range_count_next = '0;
                            table_empty_next = 1'b1;
                            last_next        = 1'b1;
                        end
                        else
                        begin
                            j_next     = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                    else if (item_count == '0)
                    begin
                        fin_append = 1'b1;
                        fin_status = STAT_EMPTY;
                    end
                    else
                    begin
                        i_next         = '0;
                        pos_next       = used_reg;
                        pos_found_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            // rd_entry holds entry i; read of i+1 is issued here
            ST_SCAN:
            begin
                if (i_reg == used_reg)
                begin
                    if (used_reg == DEPTH_C)
                    begin
                        fin_append = 1'b1;
                        fin_status = STAT_FULL;
                    end
                    else if (pos_reg == used_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = used_reg[AW-1:0];
                        used_next  = used_reg + ONE_C;
                        fin_append = 1'b1;
                        fin_status = STAT_INSERTED;
                    end
                    else
                    begin
                        rd_addr    = used_dec[AW-1:0];
                        j_next     = used_dec;
                        state_next = ST_SHUP;
                    end
                end
                else
                begin
                    alu_req.a = {1'b0, rd_entry.start};
                    alu_req.b = rd_entry.count;
                    s_next    = rd_entry.start;
                    c_next    = rd_entry.count;
                    rd_addr   = i_inc[AW-1:0];
                    if (rd_entry.start <= idx_reg && idx_ext < alu_rsp.sum)
                    begin
                        fin_append = 1'b1;
                        fin_status = STAT_CONTAINED;
                    end
                    else if (alu_rsp.sum == idx_ext)
                    begin
                        state_next = ST_EXTEND;
                    end
                    else
                    begin
                        if (!pos_found_reg && rd_entry.start >= idx_reg)
                        begin
                            pos_next       = i_reg;
                            pos_found_next = 1'b1;
                        end
                        i_next = i_inc;
                    end
                end
            end

            ST_EXTEND:
            begin
                rd_addr    = i_inc[AW-1:0];
                alu_req.a  = c_reg;
                alu_req.b  = {1'b0, cnt_reg};
                c_next     = alu_rsp.sat;
                state_next = ST_MCHECK;
            end

            // rd_entry holds entry i+1 (meaningful only when i+1 < used)
            ST_MCHECK:
            begin
                rd_addr   = i_inc[AW-1:0];
                alu_req.a = {1'b0, s_reg};
                alu_req.b = c_reg;
                if (i_inc < used_reg && alu_rsp.sum == {2'b00, rd_entry.start})
                begin
                    state_next = ST_MERGE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = i_reg[AW-1:0];
                    wr_entry   = '{start: s_reg, count: c_reg};
                    fin_append = 1'b1;
                    fin_status = STAT_EXTENDED;
                end
            end

            ST_MERGE:
            begin
                alu_req.a  = c_reg;
                alu_req.b  = rd_entry.count;
                wr_en      = 1'b1;
                wr_addr    = i_reg[AW-1:0];
                wr_entry   = '{start: s_reg, count: alu_rsp.sat};
                rd_addr    = i_inc2[AW-1:0];
                j_next     = i_inc2;
                state_next = ST_SHDN;
            end

            // close the gap: entry j moves to j-1
            ST_SHDN:
            begin
                if (j_reg < used_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = j_dec[AW-1:0];
                    wr_entry = rd_entry;
                    rd_addr  = j_inc[AW-1:0];
                    j_next   = j_inc;
                end
                else
                begin
                    used_next  = used_dec;
                    fin_append = 1'b1;
                    fin_status = STAT_MERGED;
                end
            end

            // open a gap: entry j moves to j+1, top down
            ST_SHUP:
            begin
                wr_en    = 1'b1;
                wr_addr  = j_inc[AW-1:0];
                wr_entry = rd_entry;
                if (j_reg == pos_reg)
                begin
                    state_next = ST_INSW;
                end
                else
                begin
                    rd_addr = j_dec[AW-1:0];
                    j_next  = j_dec;
                end
            end

            ST_INSW:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                used_next  = used_reg + ONE_C;
                fin_append = 1'b1;
                fin_status = STAT_INSERTED;
            end

            ST_DRAIN:
            begin
                done_next        = 1'b1;
                kind_next        = KIND_DRAIN;
                status_next      = STAT_DRAINED;
                range_start_next = offset_reg ? {1'b0, rd_entry.start, 2'b00}
                                              : {3'b000, rd_entry.start};
                range_count_next = rd_entry.count;
                table_empty_next = 1'b0;
                last_next        = (j_inc == used_reg);
                if (j_inc == used_reg)
                begin
                    used_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_addr = j_inc[AW-1:0];
                    j_next  = j_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_append)
        begin
            done_next        = 1'b1;
            kind_next        = KIND_APPEND;
            status_next      = fin_status;
            range_start_next = '0;
            range_count_next = '0;
            table_empty_next = 1'b0;
            last_next        = 1'b1;
            state_next       = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            pos_found_reg <= 1'b0;
            offset_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pos_found_reg <= pos_found_next;
            offset_reg    <= offset_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg           <= i_next;
        j_reg           <= j_next;
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        s_reg           <= s_next;
        c_reg           <= c_next;
        kind_reg        <= kind_next;
        status_reg      <= status_next;
        range_start_reg <= range_start_next;
        range_count_reg <= range_count_next;
        table_empty_reg <= table_empty_next;
        last_reg        <= last_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign range_start = range_start_reg;
    assign range_count = range_count_reg;
    assign table_empty = table_empty_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

/* design/ircu_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ircu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* design/ircu_alu.sv */
// Shared 32-bit adder with carry out and saturated sum.
`default_nettype none
module ircu_alu (
    input  wire ircu_pkg::alu_req_t req,
    output      ircu_pkg::alu_rsp_t rsp
);
    import ircu_pkg::*;

    logic [COUNT_W:0] sum;

    assign sum     = {1'b0, req.a} + {1'b0, req.b};
    assign rsp.sum = sum;
    assign rsp.sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

endmodule
`default_nettype wire

/* design/ircu_checker.sv */
// Port-level checker for the index range coalescer, bound to the top level.
`default_nettype none
module ircu_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic                          kind,
    input wire logic [2:0]                    status,
    input wire logic [ircu_pkg::OFFS_W-1:0]   range_start,
    input wire logic [ircu_pkg::COUNT_W-1:0]  range_count,
    input wire logic                          table_empty,
    input wire logic                          last
);
    import ircu_pkg::*;

    // an append gives a single, payload-free status
    a_append_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && kind == KIND_APPEND |->
            last && !table_empty && range_start == '0 && range_count == '0)
        else $error("append result malformed");

    a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (kind == KIND_DRAIN) == (status == STAT_DRAINED))
        else $error("kind and status disagree");

    a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_empty |-> kind == KIND_DRAIN && last && range_count == '0)
        else $error("empty drain result malformed");

    // drain entries come back to back until last
    a_drain_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && kind == KIND_DRAIN)
        else $error("drain burst broken");

    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("not busy during drain");

endmodule

bind index_range_coalescer_unit ircu_checker u_ircu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .kind        (kind),
    .status      (status),
    .range_start (range_start),
    .range_count (range_count),
    .table_empty (table_empty),
    .last        (last)
);
`default_nettype wire

/* bench/tb_index_range_coalescer_unit.sv */
// Self-checking bench for the index range coalescer: directed table, then random bursts.
`timescale 1ns / 100ps

module tb_index_range_coalescer_unit;
    import ircu_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED = 23;
    localparam int PRINT_CAP = 50;
    localparam logic [30:0] INDEX_MAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic               kind;
        logic [2:0]         status;
        logic [OFFS_W-1:0]  offset;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               last;
    } range_result_t;

    // op, first_index, item_count, typed, want, set_cfg, cfg_val
    typedef struct {
        logic        op;
        logic [30:0] idx;
        logic [30:0] cnt;
        logic        typed;
        logic [2:0]  want;
        logic        set_cfg;
        logic        cfg_val;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic cfg_data;
    logic start;
    logic busy;
    logic op;
    logic [START_W-1:0] first_index;
    logic [START_W-1:0] item_count;
    logic done;
    logic kind;
    logic [2:0] status;
    logic [OFFS_W-1:0] range_start;
    logic [COUNT_W-1:0] range_count;
    logic table_empty;
    logic last;

    // mirror of the range table and the offset register
    logic [30:0] mirror_start [TABLE_DEPTH];
    logic [31:0] mirror_count [TABLE_DEPTH];
    int          mirror_used;
    logic        mirror_bytes;

    range_result_t awaited_results [$];
    int mismatches;
    int cycle_count;
    int results_seen;
    int n_appends;
    int n_drains;
    int status_tally [8];

    probe_t directed_rows [N_DIRECTED] = '{
        '{OP_DRAIN,  31'd0,         31'd0,         1'b1, STAT_DRAINED,   1'b0, 1'b0},
        '{OP_APPEND, 31'd5,         31'd0,         1'b1, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd100,       31'd10,        1'b1, STAT_INSERTED,  1'b0, 1'b0},
        '{OP_APPEND, 31'd105,       31'd3,         1'b1, STAT_CONTAINED, 1'b0, 1'b0},
        '{OP_APPEND, 31'd110,       31'd5,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd130,       31'd4,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd115,       31'd15,        1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd0,         31'd1,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, INDEX_MAX,     INDEX_MAX,     1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd50,        INDEX_MAX,     1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd1,         31'd1,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_DRAIN,  INDEX_MAX,     INDEX_MAX,     1'b0, STAT_EMPTY,     1'b1, 1'b1},
        '{OP_DRAIN,  31'd0,         31'd0,         1'b1, STAT_DRAINED,   1'b0, 1'b0},
        '{OP_APPEND, 31'd0,         31'd1,         1'b1, STAT_INSERTED,  1'b0, 1'b0},
        '{OP_APPEND, 31'd2,         31'h7FFFFFFD,  1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, INDEX_MAX,     INDEX_MAX,     1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'd1,         31'd1,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, INDEX_MAX,     31'd1,         1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, INDEX_MAX,     31'd0,         1'b1, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_DRAIN,  31'd0,         31'd0,         1'b0, STAT_EMPTY,     1'b1, 1'b0},
        '{OP_APPEND, 31'h2AAAAAAA,  31'h55555555,  1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_APPEND, 31'h55555555,  31'h2AAAAAAA,  1'b0, STAT_EMPTY,     1'b0, 1'b0},
        '{OP_DRAIN,  31'h55555555,  31'h2AAAAAAA,  1'b0, STAT_EMPTY,     1'b0, 1'b0}
    };

    index_range_coalescer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .first_index (first_index),
        .item_count  (item_count),
        .done        (done),
        .kind        (kind),
        .status      (status),
        .range_start (range_start),
        .range_count (range_count),
        .table_empty (table_empty),
        .last        (last)
    );

    always #2 clk = ~clk;

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic logic [63:0] sat32(logic [63:0] v);
        return (v > 64'hFFFFFFFF) ? 64'hFFFFFFFF : v;
    endfunction

    function automatic void add_expected(range_result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Append: first matching entry in ascending order decides the status.
    function automatic logic [2:0] coalesce_range(logic [30:0] idx, logic [30:0] cnt);
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] c;
        int i;
        int j;
        int pos;
        if (cnt == 0)
            return STAT_EMPTY;
        for (i = 0; i < mirror_used; i++) begin
            s = mirror_start[i];
            e = s + mirror_count[i];
            if (s <= idx && idx < e)
                return STAT_CONTAINED;
            if (e == idx) begin
                c = mirror_count[i];
                c = sat32(c + cnt);
                mirror_count[i] = c[31:0];
                if (i + 1 < mirror_used && s + c == mirror_start[i + 1]) begin
                    c = sat32(c + mirror_count[i + 1]);
                    mirror_count[i] = c[31:0];
                    for (j = i + 1; j < mirror_used - 1; j++) begin
                        mirror_start[j] = mirror_start[j + 1];
                        mirror_count[j] = mirror_count[j + 1];
                    end
                    mirror_used--;
                    return STAT_MERGED;
                end
                return STAT_EXTENDED;
            end
        end
        if (mirror_used >= TABLE_DEPTH)
            return STAT_FULL;
        pos = 0;
        while (pos < mirror_used && mirror_start[pos] < idx)
            pos++;
        for (j = mirror_used; j > pos; j--) begin
            mirror_start[j] = mirror_start[j - 1];
            mirror_count[j] = mirror_count[j - 1];
        end
        mirror_start[pos] = idx;
        mirror_count[pos] = {1'b0, cnt};
        mirror_used++;
        return STAT_INSERTED;
    endfunction

    function automatic void drain_table();
        range_result_t r;
        int i;
        r = '0;
        r.kind = KIND_DRAIN;
        r.status = STAT_DRAINED;
        if (mirror_used == 0) begin
            r.empty = 1'b1;
            r.last = 1'b1;
            add_expected(r);
            return;
        end
        for (i = 0; i < mirror_used; i++) begin
            r.offset = mirror_bytes ? {1'b0, mirror_start[i], 2'b00} : OFFS_W'(mirror_start[i]);
            r.count = mirror_count[i];
            r.last = (i == mirror_used - 1);
            add_expected(r);
        end
        mirror_used = 0;
    endfunction

    function automatic void model_transaction(logic o, logic [30:0] idx, logic [30:0] cnt);
        range_result_t r;
        if (o == OP_DRAIN) begin
            drain_table();
        end
        else begin
            r = '0;
            r.kind = KIND_APPEND;
            r.status = coalesce_range(idx, cnt);
            r.last = 1'b1;
            add_expected(r);
        end
    endfunction

    // Present one transaction, hold it until accepted, then predict its results.
    task automatic issue(logic o, logic [30:0] idx, logic [30:0] cnt, int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        first_index <= idx;
        item_count <= cnt;
        do @(posedge clk); while (busy);
        if (o == OP_DRAIN)
            n_drains++;
        else
            n_appends++;
        model_transaction(o, idx, cnt);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0 || busy);
    endtask

    task automatic set_byte_offsets(logic v);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        mirror_bytes = v;
    endtask

    // Bursts of appends around a window, each closed by a drain. A fill burst
    // inserts widely spaced ranges until the table overflows.
    task automatic run_phase(int quota, int idle_pct, bit with_fill);
        int sent;
        int n;
        int j;
        int k;
        int pick;
        int span;
        bit fill;
        bit mid_drain;
        logic [30:0] base;
        logic [30:0] idx;
        logic [30:0] cnt;
        logic [63:0] e;
        sent = 0;
        fill = with_fill;
        while (sent < quota) begin
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = 31'h7FFFFC00;
                default: base = 31'($urandom_range(0, 32'h7FFFFC00));
            endcase
            n = fill ? 40 : $urandom_range(2, 14);
            for (j = 0; j < n; j++) begin
                mid_drain = 1'b0;
                idx = base + 31'($urandom_range(0, 400));
                cnt = 31'($urandom_range(1, 30));
                pick = $urandom_range(0, 99);
                if (fill) begin
                    k = (j * 13) % 40;
                    idx = 31'(k * 32'h3000000 + $urandom_range(0, 1000));
                    cnt = 31'($urandom_range(1, 1000));
                end
                else if (pick < 8) begin
                    idx = 31'($urandom);
                    cnt = '0;
                end
                else if (pick < 16) begin
                    idx = 31'($urandom);
                    cnt = 31'($urandom);
                end
                else if (pick < 36) begin
                    // new range near the window
                end
                else if (pick < 66 && mirror_used > 0) begin
                    k = $urandom_range(0, mirror_used - 1);
                    e = 64'(mirror_start[k]) + mirror_count[k];
                    if (e <= INDEX_MAX) begin
                        idx = e[30:0];
                        // close the gap exactly to provoke a merge
                        if (k + 1 < mirror_used && mirror_start[k + 1] > e && $urandom_range(0, 1))
                            cnt = mirror_start[k + 1] - e[30:0];
                    end
                end
                else if (pick < 90 && mirror_used > 0) begin
                    k = $urandom_range(0, mirror_used - 1);
                    span = (mirror_count[k] > 1000) ? 999 : int'(mirror_count[k]) - 1;
                    e = 64'(mirror_start[k]) + $urandom_range(0, span);
                    if (e <= INDEX_MAX)
                        idx = e[30:0];
                    cnt = 31'($urandom_range(1, 50));
                end
                else if (pick >= 95) begin
                    mid_drain = 1'b1;
                end
                if (mid_drain)
                    issue(OP_DRAIN, 31'($urandom), 31'($urandom), idle_pct);
                else
                    issue(OP_APPEND, idx, cnt, idle_pct);
                if (mid_drain || cnt != 0)
                    sent++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_quiet();
            issue(OP_DRAIN, 31'($urandom), 31'($urandom), idle_pct);
            sent++;
            fill = 1'b0;
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk) begin : result_check
        range_result_t want;
        if (rst_n && done) begin
            results_seen++;
            status_tally[status]++;
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: kind %0d status %0d start %0h",
                                        kind, status, range_start));
            end
            else begin
                want = awaited_results.pop_front();
                check_field("kind", 64'(kind), 64'(want.kind));
                check_field("status", 64'(status), 64'(want.status));
                check_field("range_start", 64'(range_start), 64'(want.offset));
                check_field("range_count", 64'(range_count), 64'(want.count));
                check_field("table_empty", 64'(table_empty), 64'(want.empty));
                check_field("last", 64'(last), 64'(want.last));
            end
        end
    end

    initial begin : stimulus
        range_result_t typed;
        int i;
        mismatches = 0;
        cycle_count = 0;
        results_seen = 0;
        n_appends = 0;
        n_drains = 0;
        for (i = 0; i < 8; i++)
            status_tally[i] = 0;
        mirror_used = 0;
        mirror_bytes = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= 1'b0;
        start <= 1'b0;
        op <= OP_APPEND;
        first_index <= '0;
        item_count <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].set_cfg)
                set_byte_offsets(directed_rows[i].cfg_val);
            issue(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].cnt, 35);
            if (directed_rows[i].typed) begin
                typed = '0;
                typed.kind = directed_rows[i].op;
                typed.status = directed_rows[i].want;
                typed.empty = (directed_rows[i].op == OP_DRAIN);
                typed.last = 1'b1;
                awaited_results[$] = typed;
            end
        end

        run_phase(30, 35, 1'b0);
        set_byte_offsets(1'b1);
        run_phase(40, 62, 1'b1);
        set_byte_offsets(1'b0);
        run_phase(10, 0, 1'b0);
        wait_quiet();
        run_phase(10, 0, 1'b0);

        start <= 1'b0;
        for (i = 0; i < 5000 && (awaited_results.size() != 0 || busy); i++)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                                    awaited_results.size()));

        $display("Covered %0d appends and %0d drains, %0d results checked, %0d mismatches",
                 n_appends, n_drains, results_seen, mismatches);
        $display({"Statuses: ignored %0d contained %0d extended %0d merged %0d",
                  " inserted %0d full %0d drained %0d"},
                 status_tally[STAT_EMPTY], status_tally[STAT_CONTAINED],
                 status_tally[STAT_EXTENDED], status_tally[STAT_MERGED],
                 status_tally[STAT_INSERTED], status_tally[STAT_FULL],
                 status_tally[STAT_DRAINED]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
